[hdl/satq_pkg.sv]
// Shared types and constants for the sorted alarm timer queue.
// No dependencies; imported by sorted_alarm_timer_queue.
`default_nettype none

package satq_pkg;

    // default sizes
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 8;

    // at most this many expiries leave the queue on one tick
    localparam int MAX_RESULTS = 16;

    localparam logic [31:0] MAX_DISTANCE_RESET = 32'd8388608;

    // input item modes
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_DISTANT  = 2'd1;
    localparam logic [1:0] STAT_INACTIVE = 2'd2;
    localparam logic [1:0] STAT_FULL     = 2'd3;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_T_RD,
        S_T_USE,
        S_T_LAST,
        S_MV_RD,
        S_MV_USE,
        S_A_DIFF,
        S_A_CHK,
        S_R_RD,
        S_R_USE,
        S_P_NEXT,
        S_I_START,
        S_I_RD,
        S_I_USE,
        S_I_WR,
        S_RESP
    } state_t;

endpackage : satq_pkg

`default_nettype wire

[hdl/satq_store.sv]
// Timer entry store: trigger time and id per slot, one write and one read port.
// Read data is registered. Depends on nothing but its parameters.
`default_nettype none

module satq_store #(
    parameter int DEPTH = 16,
    parameter int IDW   = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [63:0]                wr_time,
    input  wire logic [IDW-1:0]             wr_id,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [63:0]                rd_time,
    output logic      [IDW-1:0]             rd_id
);

    logic [63:0]    mem_time [DEPTH];
    logic [IDW-1:0] mem_id   [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_time[wr_addr] <= wr_time;
            mem_id[wr_addr]   <= wr_id;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_time <= mem_time[rd_addr];
            rd_id   <= mem_id[rd_addr];
        end
    end

endmodule : satq_store

`default_nettype wire

[hdl/sorted_alarm_timer_queue.sv]
// Sorted alarm timer queue: 64-bit tick time base and a time-ordered timer table.
// Depends on satq_pkg and satq_store.
//
//  channel | dir | handshake                | payload
//  --------+-----+--------------------------+----------------------------------------
//  s_      | in  | s_tvalid / s_tready      | tuser mode, tdata id + due time
//  m_      | out | m_tvalid / m_tready      | tuser kind, tdata status/id/time, tlast
//  cfg_    | in  | cfg_we                   | cfg_wdata = max_distance
//
// One item at a time: each table entry read or moved takes a read step and a use
// step on the entry store (registered read). A tick reads the expired entries,
// emits the final expiry and moves the survivors down to the head; on an empty
// table it only advances the time base. Reset clears time, count and control;
// the entry store needs no clearing. s_tready is high only when the
// sequencer is idle; a stalled m_ side holds the sequencer at the step that emits.
`default_nettype none

module sorted_alarm_timer_queue
    import satq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_BITS     = ID_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // [7:0] timer_id, [71:8] due_time
    input  wire logic [1:0]  s_tuser,   // [1:0] mode
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [79:0] m_tdata,   // [1:0] status, [9:2] expired_id,
                                        // [73:10] time_now, [79:74] zero
    output logic      [0:0]  m_tuser,   // [0] kind
    output logic             m_tlast,
    // configuration
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_wdata
);

    localparam int IW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW  = $clog2(QUEUE_DEPTH + 1);
    localparam int IDW = ID_BITS;
    localparam int IDX = (ID_BITS > 8) ? ID_BITS : 8;

    state_t state_reg, state_next;
    state_t mv_ret_reg, mv_ret_next;

    logic [63:0]    time_reg, time_next;
    logic [31:0]    maxd_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  k_reg, k_next;
    logic [IDW-1:0] pend_id_reg, pend_id_next;
    logic           pend_v_reg, pend_v_next;
    logic [CW-1:0]  mv_src_reg, mv_src_next;
    logic [CW-1:0]  mv_dst_reg, mv_dst_next;
    logic [CW-1:0]  mv_steps_reg, mv_steps_next;
    logic           mv_dn_reg, mv_dn_next;
    logic           op_add_reg, op_add_next;
    logic [IDW-1:0] id_reg, id_next;
    logic [63:0]    target_reg, target_next;
    logic [63:0]    diff_reg, diff_next;
    logic           gt_reg, gt_next;
    logic [1:0]     status_reg, status_next;

    logic           m_tvalid_reg;
    logic           m_kind_reg;
    logic [1:0]     m_status_reg;
    logic [7:0]     m_id_reg;
    logic [63:0]    m_time_reg;
    logic           m_last_reg;

    // store port signals
    logic           wr_en, rd_en;
    logic [IW-1:0]  wr_addr, rd_addr;
    logic [63:0]    wr_time, rd_time;
    logic [IDW-1:0] wr_id, rd_id;

    // result load
    logic           out_load, out_kind, out_last;
    logic [1:0]     out_status;
    logic [IDW-1:0] out_id;
    logic [IDX-1:0] out_id_wide;

    // shared decode
    logic           s_fire, out_free;
    logic [IDX-1:0] id_in_wide;
    logic [IDW-1:0] id_in;
    logic [CW-1:0]  idx_inc, k_inc;
    logic           more, k_room, t_exp, id_hit, i_le, too_far, tbl_full;
    logic [63:0]    cmp_ref;
    logic [64:0]    sub_w;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_fire     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign id_in_wide = IDX'(s_tdata[7:0]);
    assign id_in      = id_in_wide[IDW-1:0];
    assign idx_inc    = idx_reg + CW'(1);
    assign k_inc      = k_reg + CW'(1);
    assign more       = idx_inc < count_reg;
    assign k_room     = 32'(k_inc) < MAX_RESULTS;
    // one time comparator: against now on a tick scan, against the target on insert
    assign cmp_ref    = op_add_reg ? target_reg : time_reg;
    assign t_exp      = rd_time <= cmp_ref;
    assign i_le       = t_exp;
    assign id_hit     = rd_id == id_reg;
    assign too_far    = gt_reg && ((diff_reg[63:32] != 32'd0) || (diff_reg[31:0] > maxd_reg));
    assign tbl_full   = count_reg >= CW'(QUEUE_DEPTH);
    assign sub_w      = {1'b0, target_reg} - {1'b0, time_reg};

    satq_store #(
        .DEPTH (QUEUE_DEPTH),
        .IDW   (IDW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_time (wr_time),
        .wr_id   (wr_id),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_time (rd_time),
        .rd_id   (rd_id)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_tuser)
                        MODE_TICK:   state_next = (count_reg == '0) ? S_IDLE : S_T_RD;
                        MODE_ADD:    state_next = S_A_DIFF;
                        MODE_REMOVE: state_next = (count_reg == '0) ? S_RESP : S_R_RD;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_T_RD:  state_next = S_T_USE;
            S_T_USE: begin
                if (t_exp) begin
                    if (!pend_v_reg || out_free) begin
                        state_next = (more && k_room) ? S_T_RD : S_T_LAST;
                    end
                end else begin
                    state_next = pend_v_reg ? S_T_LAST : S_IDLE;
                end
            end
            S_T_LAST: begin
                if (out_free) begin
                    state_next = (count_reg == k_reg) ? S_IDLE : S_MV_RD;
                end
            end
            S_MV_RD:  state_next = S_MV_USE;
            S_MV_USE: state_next = (mv_steps_reg == CW'(1)) ? mv_ret_reg : S_MV_RD;
            S_A_DIFF: state_next = S_A_CHK;
            S_A_CHK: begin
                if (too_far) begin
                    state_next = S_RESP;
                end else begin
                    state_next = (count_reg == '0) ? S_I_START : S_R_RD;
                end
            end
            S_R_RD:  state_next = S_R_USE;
            S_R_USE: begin
                if (id_hit) begin
                    state_next = (idx_inc == count_reg) ? S_P_NEXT : S_MV_RD;
                end else if (more) begin
                    state_next = S_R_RD;
                end else begin
                    state_next = op_add_reg ? S_I_START : S_RESP;
                end
            end
            S_P_NEXT: state_next = op_add_reg ? S_I_START : S_RESP;
            S_I_START: begin
                if (tbl_full) begin
                    state_next = S_RESP;
                end else begin
                    state_next = (count_reg == '0) ? S_I_WR : S_I_RD;
                end
            end
            S_I_RD:  state_next = S_I_USE;
            S_I_USE: begin
                if (i_le) begin
                    state_next = more ? S_I_RD : S_I_WR;
                end else begin
                    state_next = S_MV_RD;
                end
            end
            S_I_WR:  state_next = S_RESP;
            S_RESP:  state_next = out_free ? S_IDLE : S_RESP;
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, store access and result load
    always_comb begin
        time_next     = time_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        pend_id_next  = pend_id_reg;
        pend_v_next   = pend_v_reg;
        mv_src_next   = mv_src_reg;
        mv_dst_next   = mv_dst_reg;
        mv_steps_next = mv_steps_reg;
        mv_dn_next    = mv_dn_reg;
        mv_ret_next   = mv_ret_reg;
        op_add_next   = op_add_reg;
        id_next       = id_reg;
        target_next   = target_reg;
        diff_next     = diff_reg;
        gt_next       = gt_reg;
        status_next   = status_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_reg[IW-1:0];
        wr_en         = 1'b0;
        wr_addr       = mv_dst_reg[IW-1:0];
        wr_time       = rd_time;
        wr_id         = rd_id;
        out_load      = 1'b0;
        out_kind      = KIND_STATUS;
        out_status    = status_reg;
        out_id        = id_reg;
        out_last      = 1'b1;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    id_next     = id_in;
                    target_next = s_tdata[71:8];
                    op_add_next = (s_tuser == MODE_ADD);
                    idx_next    = '0;
                    k_next      = '0;
                    pend_v_next = 1'b0;
                    status_next = STAT_OK;
                    if (s_tuser == MODE_TICK) begin
                        time_next = time_reg + 64'd1;
                    end
                    if (s_tuser == MODE_REMOVE && count_reg == '0) begin
                        status_next = STAT_INACTIVE;
                    end
                end
            end
            S_T_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[IW-1:0];
            end
            // expired head: flush the held expiry (not last), hold this one
            S_T_USE: begin
                if (t_exp && (!pend_v_reg || out_free)) begin
                    out_load     = pend_v_reg;
                    out_kind     = KIND_EXPIRY;
                    out_status   = STAT_OK;
                    out_id       = pend_id_reg;
                    out_last     = 1'b0;
                    pend_id_next = rd_id;
                    pend_v_next  = 1'b1;
                    k_next       = k_inc;
                    idx_next     = idx_inc;
                end
            end
            // final expiry, then slide the survivors down to the head
            S_T_LAST: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_kind      = KIND_EXPIRY;
                    out_status    = STAT_OK;
                    out_id        = pend_id_reg;
                    out_last      = 1'b1;
                    count_next    = count_reg - k_reg;
                    mv_src_next   = k_reg;
                    mv_dst_next   = '0;
                    mv_steps_next = count_reg - k_reg;
                    mv_dn_next    = 1'b0;
                    mv_ret_next   = S_IDLE;
                end
            end
            S_MV_RD: begin
                rd_en   = 1'b1;
                rd_addr = mv_src_reg[IW-1:0];
            end
            S_MV_USE: begin
                wr_en         = 1'b1;
                wr_addr       = mv_dst_reg[IW-1:0];
                wr_time       = rd_time;
                wr_id         = rd_id;
                mv_steps_next = mv_steps_reg - CW'(1);
                if (mv_dn_reg) begin
                    mv_src_next = mv_src_reg - CW'(1);
                    mv_dst_next = mv_dst_reg - CW'(1);
                end else begin
                    mv_src_next = mv_src_reg + CW'(1);
                    mv_dst_next = mv_dst_reg + CW'(1);
                end
            end
            // distance of the target from now
            S_A_DIFF: begin
                diff_next = sub_w[63:0];
                gt_next   = !sub_w[64] && (sub_w[63:0] != 64'd0);
            end
            S_A_CHK: begin
                idx_next = '0;
                if (too_far) begin
                    status_next = STAT_DISTANT;
                end
            end
            S_R_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[IW-1:0];
            end
            // id search; a hit closes the gap above it
            S_R_USE: begin
                if (id_hit) begin
                    count_next    = count_reg - CW'(1);
                    mv_src_next   = idx_inc;
                    mv_dst_next   = idx_reg;
                    mv_steps_next = count_reg - idx_inc;
                    mv_dn_next    = 1'b0;
                    mv_ret_next   = S_P_NEXT;
                    status_next   = STAT_OK;
                end else begin
                    idx_next = idx_inc;
                    if (!more && !op_add_reg) begin
                        status_next = STAT_INACTIVE;
                    end
                end
            end
            S_I_START: begin
                idx_next = '0;
                if (tbl_full) begin
                    status_next = STAT_FULL;
                end
            end
            S_I_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_reg[IW-1:0];
            end
            // insert point is after all entries with time at or before target
            S_I_USE: begin
                if (i_le) begin
                    idx_next = idx_inc;
                end else begin
                    mv_src_next   = count_reg - CW'(1);
                    mv_dst_next   = count_reg;
                    mv_steps_next = count_reg - idx_reg;
                    mv_dn_next    = 1'b1;
                    mv_ret_next   = S_I_WR;
                end
            end
            S_I_WR: begin
                wr_en       = 1'b1;
                wr_addr     = idx_reg[IW-1:0];
                wr_time     = target_reg;
                wr_id       = id_reg;
                count_next  = count_reg + CW'(1);
                status_next = STAT_OK;
            end
            S_RESP: begin
                out_load = out_free;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            time_reg   <= 64'd0;
            count_reg  <= '0;
            maxd_reg   <= MAX_DISTANCE_RESET;
            pend_v_reg <= 1'b0;
            k_reg      <= '0;
        end else begin
            state_reg  <= state_next;
            time_reg   <= time_next;
            count_reg  <= count_next;
            pend_v_reg <= pend_v_next;
            k_reg      <= k_next;
            if (cfg_we) begin
                maxd_reg <= cfg_wdata;
            end
        end
    end

    // work registers
    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        pend_id_reg  <= pend_id_next;
        mv_src_reg   <= mv_src_next;
        mv_dst_reg   <= mv_dst_next;
        mv_steps_reg <= mv_steps_next;
        mv_dn_reg    <= mv_dn_next;
        mv_ret_reg   <= mv_ret_next;
        op_add_reg   <= op_add_next;
        id_reg       <= id_next;
        target_reg   <= target_next;
        diff_reg     <= diff_next;
        gt_reg       <= gt_next;
        status_reg   <= status_next;
    end

    // output register
    assign out_id_wide = IDX'(out_id);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kind_reg   <= out_kind;
            m_status_reg <= out_status;
            m_id_reg     <= out_id_wide[7:0];
            m_time_reg   <= time_reg;
            m_last_reg   <= out_last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = {6'd0, m_time_reg, m_id_reg, m_status_reg};
    assign m_tuser[0] = m_kind_reg;
    assign m_tlast    = m_last_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("entry count above table depth");

    a_expiry_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(k_reg) <= MAX_RESULTS)
        else $error("too many expiries on one tick");

    a_time_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_fire && s_tuser == MODE_TICK) |=> $stable(time_reg))
        else $error("time base moved without a tick");

    a_empty_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == MODE_TICK && count_reg == '0) |=> state_reg == S_IDLE)
        else $error("tick on empty table did not return to idle");

    a_resp_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && out_free) |=> (m_tvalid && m_tlast && !m_tuser[0]))
        else $error("status answer not presented as last status item");

endmodule : sorted_alarm_timer_queue

`default_nettype wire
